>>> hdl/smeu_pkg.sv
// Shared types, constants and codes for the stack machine execute unit.
package smeu_pkg;

    localparam int DATA_DEPTH   = 64;
    localparam int RETURN_DEPTH = 16;
    localparam int REG_COUNT    = 6;

    localparam int DAW = $clog2(DATA_DEPTH);
    localparam int DCW = $clog2(DATA_DEPTH + 1);
    localparam int RAW = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;
    localparam int RCW = $clog2(RETURN_DEPTH + 1);
    localparam int RIW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    typedef enum logic [4:0] {
        OP_PUSH    = 5'd0,
        OP_OUT     = 5'd1,
        OP_PUSHREG = 5'd2,
        OP_POPREG  = 5'd3,
        OP_ADD     = 5'd4,
        OP_SUB     = 5'd5,
        OP_MUL     = 5'd6,
        OP_DIV     = 5'd7,
        OP_POW     = 5'd8,
        OP_SQRT    = 5'd9,
        OP_JB      = 5'd10,
        OP_JBE     = 5'd11,
        OP_JA      = 5'd12,
        OP_JAE     = 5'd13,
        OP_JE      = 5'd14,
        OP_JNE     = 5'd15,
        OP_JMP     = 5'd16,
        OP_CALL    = 5'd17,
        OP_RET     = 5'd18
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FEW     = 3'd1,
        ST_DIV0    = 3'd2,
        ST_ZPZ     = 3'd3,
        ST_SQRTNEG = 3'd4,
        ST_BADCMD  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_ITER
    } state_t;

    typedef enum logic [1:0] {
        IT_DIV,
        IT_POW,
        IT_SQRT
    } it_op_t;

    typedef struct packed {
        logic [4:0]         opcode;
        logic signed [31:0] operand_value;
        logic [2:0]         reg_index;
        logic [15:0]        jump_target;
        logic [15:0]        instr_addr;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               out_valid;
        logic signed [31:0] out_value;
        logic [15:0]        next_addr;
    } out_item_t;

    typedef struct packed {
        logic latch;
        logic rd;
        logic it_start;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic iter_req;
        logic it_done;
        logic out_free;
    } dp_stat_t;

endpackage

>>> hdl/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit.
//
//  channel | direction | handshake           | beat
//  s_      | in        | s_valid / s_ready   | smeu_pkg::in_item_t
//  m_      | out       | m_valid / m_ready   | smeu_pkg::out_item_t
//
// One instruction at a time: accept, operand read from the data stack
// memory, execute and commit. Divide, power with a non-negative
// exponent and square root go through the iterative unit: 32 steps
// for divide and power, 16 for square root.
// Synchronous active-low reset empties both stacks and clears the registers.
// A stalled m_ side holds the commit; the next beat is not taken meanwhile.
module stack_machine_execute_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  smeu_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output smeu_pkg::out_item_t m_data
);
    import smeu_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    smeu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    smeu_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> hdl/smeu_iter.sv
// Iterative unit for divide, integer power and square root.
module smeu_iter (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  smeu_pkg::it_op_t op,
    input  logic [31:0]     opa,
    input  logic [31:0]     opb,
    output logic            done,
    output logic [31:0]     result
);
    import smeu_pkg::*;

    it_op_t      op_reg;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  step_reg, step_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] xq_reg, xq_next;
    logic [31:0] yd_reg, yd_next;
    logic        neg_reg;

    logic [32:0] t33, sub33;
    logic [33:0] t34, tr34, sub34;
    logic [63:0] prod_r, prod_b;
    logic [31:0] ma, mb;

    assign ma = opa[31] ? (32'd0 - opa) : opa;
    assign mb = opb[31] ? (32'd0 - opb) : opb;

    always_comb begin
        t33    = {acc_reg, xq_reg[31]};
        sub33  = t33 - {1'b0, yd_reg};
        t34    = {acc_reg, xq_reg[31:30]};
        tr34   = {yd_reg, 2'b01};
        sub34  = t34 - tr34;
        prod_r = acc_reg * xq_reg;
        prod_b = xq_reg * xq_reg;
        acc_next  = acc_reg;
        xq_next   = xq_reg;
        yd_next   = yd_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        if (busy_reg) begin
            case (op_reg)
                IT_DIV: begin
                    if (t33 >= {1'b0, yd_reg}) begin
                        acc_next = sub33[31:0];
                        xq_next  = {xq_reg[30:0], 1'b1};
                    end else begin
                        acc_next = t33[31:0];
                        xq_next  = {xq_reg[30:0], 1'b0};
                    end
                end
                IT_SQRT: begin
                    if (t34 >= tr34) begin
                        acc_next = sub34[31:0];
                        yd_next  = {yd_reg[30:0], 1'b1};
                    end else begin
                        acc_next = t34[31:0];
                        yd_next  = {yd_reg[30:0], 1'b0};
                    end
                    xq_next = {xq_reg[29:0], 2'b00};
                end
                default: begin
                    if (yd_reg[0]) begin
                        acc_next = prod_r[31:0];
                    end
                    xq_next = prod_b[31:0];
                    yd_next = {1'b0, yd_reg[31:1]};
                end
            endcase
            step_next = step_reg - 6'd1;
            if (step_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 6'd0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= (op == IT_SQRT) ? 6'd16 : 6'd32;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            op_reg  <= op;
            neg_reg <= opa[31] ^ opb[31];
            case (op)
                IT_DIV: begin
                    acc_reg <= 32'd0;
                    xq_reg  <= mb;
                    yd_reg  <= ma;
                end
                IT_SQRT: begin
                    acc_reg <= 32'd0;
                    xq_reg  <= opa;
                    yd_reg  <= 32'd0;
                end
                default: begin
                    acc_reg <= 32'd1;
                    xq_reg  <= opb;
                    yd_reg  <= opa;
                end
            endcase
        end else begin
            acc_reg <= acc_next;
            xq_reg  <= xq_next;
            yd_reg  <= yd_next;
        end
    end

    assign done = done_reg;

    always_comb begin
        case (op_reg)
            IT_DIV:  result = neg_reg ? (32'd0 - xq_reg) : xq_reg;
            IT_SQRT: result = yd_reg;
            default: result = acc_reg;
        endcase
    end

endmodule

>>> hdl/smeu_dpath.sv
// Datapath: stacks, register file, arithmetic and the result register.
module smeu_dpath (
    input  logic                aclk,
    input  logic                aresetn,
    input  smeu_pkg::ctrl_cmd_t cmd,
    output smeu_pkg::dp_stat_t  stat,
    input  smeu_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output smeu_pkg::out_item_t m_data
);
    import smeu_pkg::*;

    in_item_t    item_reg;
    logic [31:0] dmem [DATA_DEPTH];
    logic [31:0] rd_a_reg, rd_b_reg;
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic [15:0] rstack_reg [RETURN_DEPTH];
    logic [RCW-1:0] rcnt_reg, rcnt_next;
    logic [31:0] regs_reg [REG_COUNT];
    logic        m_valid_reg;
    out_item_t   m_item_reg;

    logic [DCW-1:0] dm1, dm2, dbase;
    logic [RCW-1:0] rm1;
    logic [DAW-1:0] wa;
    logic [RAW-1:0] rtop_idx;
    logic [RIW-1:0] ridx;
    logic        full, have1, have2, idx_ok, rfull, take;
    logic [31:0] a, b, push_val, simple_val, it_result;
    logic [63:0] prod;
    logic [15:0] ia_p1;
    logic        it_done;

    status_t     st;
    logic        ovalid, push_en, reg_we, rs_push, rs_pop, iter_req;
    logic [31:0] ov;
    logic [15:0] nxt;
    logic [1:0]  pop_n;
    it_op_t      it_op;

    assign a        = rd_a_reg;
    assign b        = rd_b_reg;
    assign dm1      = dcnt_reg - DCW'(1);
    assign dm2      = dcnt_reg - DCW'(2);
    assign rm1      = rcnt_reg - RCW'(1);
    assign rtop_idx = rm1[RAW-1:0];
    assign ridx     = item_reg.reg_index[RIW-1:0];
    assign full     = (dcnt_reg == DCW'(DATA_DEPTH));
    assign have1    = (dcnt_reg != '0);
    assign have2    = (dcnt_reg > DCW'(1));
    assign idx_ok   = ({1'b0, item_reg.reg_index} < 4'(REG_COUNT));
    assign rfull    = (rcnt_reg == RCW'(RETURN_DEPTH));
    assign prod     = b * a;
    assign ia_p1    = item_reg.instr_addr + 16'd1;

    always_comb begin
        st         = ST_OK;
        ovalid     = 1'b0;
        ov         = 32'd0;
        nxt        = item_reg.instr_addr;
        push_en    = 1'b0;
        simple_val = item_reg.operand_value;
        pop_n      = 2'd0;
        reg_we     = 1'b0;
        rs_push    = 1'b0;
        rs_pop     = 1'b0;
        iter_req   = 1'b0;
        it_op      = IT_DIV;
        take       = 1'b0;
        unique case (item_reg.opcode)
            OP_PUSH: begin
                if (full) st = ST_BADCMD;
                else push_en = 1'b1;
            end
            OP_OUT: begin
                if (!have1) st = ST_FEW;
                else begin
                    pop_n  = 2'd1;
                    ovalid = 1'b1;
                    ov     = a;
                end
            end
            OP_PUSHREG: begin
                if (!idx_ok || full) st = ST_BADCMD;
                else begin
                    push_en    = 1'b1;
                    simple_val = regs_reg[ridx];
                end
            end
            OP_POPREG: begin
                if (!idx_ok) st = ST_BADCMD;
                else if (!have1) st = ST_FEW;
                else begin
                    pop_n  = 2'd1;
                    reg_we = 1'b1;
                end
            end
            OP_ADD, OP_SUB, OP_MUL: begin
                if (!have2) st = ST_FEW;
                else begin
                    pop_n   = 2'd2;
                    push_en = 1'b1;
                    case (item_reg.opcode)
                        OP_ADD:  simple_val = b + a;
                        OP_SUB:  simple_val = b - a;
                        default: simple_val = prod[31:0];
                    endcase
                end
            end
            OP_DIV: begin
                if (!have2) st = ST_FEW;
                else begin
                    pop_n = 2'd2;
                    if (a == 32'd0) st = ST_DIV0;
                    else begin
                        push_en  = 1'b1;
                        iter_req = 1'b1;
                        it_op    = IT_DIV;
                    end
                end
            end
            OP_POW: begin
                if (!have2) st = ST_FEW;
                else begin
                    pop_n = 2'd2;
                    if (a == 32'd0 && b == 32'd0) st = ST_ZPZ;
                    else begin
                        push_en = 1'b1;
                        if (a[31]) begin
                            // negative exponent: only unit bases survive
                            if (b == 32'd1) simple_val = 32'd1;
                            else if (b == 32'hFFFF_FFFF)
                                simple_val = a[0] ? 32'hFFFF_FFFF : 32'd1;
                            else simple_val = 32'd0;
                        end else begin
                            iter_req = 1'b1;
                            it_op    = IT_POW;
                        end
                    end
                end
            end
            OP_SQRT: begin
                if (!have1) st = ST_FEW;
                else begin
                    pop_n = 2'd1;
                    if (a[31]) st = ST_SQRTNEG;
                    else begin
                        push_en  = 1'b1;
                        iter_req = 1'b1;
                        it_op    = IT_SQRT;
                    end
                end
            end
            OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE: begin
                if (!have2) st = ST_FEW;
                else begin
                    pop_n = 2'd2;
                    case (item_reg.opcode)
                        OP_JB:   take = $signed(b) < $signed(a);
                        OP_JBE:  take = !($signed(a) < $signed(b));
                        OP_JA:   take = $signed(a) < $signed(b);
                        OP_JAE:  take = !($signed(b) < $signed(a));
                        OP_JE:   take = (a == b);
                        default: take = (a != b);
                    endcase
                    nxt = take ? item_reg.jump_target : ia_p1;
                end
            end
            OP_JMP: nxt = item_reg.jump_target;
            OP_CALL: begin
                if (rfull) st = ST_BADCMD;
                else begin
                    rs_push = 1'b1;
                    nxt     = item_reg.jump_target;
                end
            end
            OP_RET: begin
                if (rcnt_reg == '0) st = ST_FEW;
                else begin
                    rs_pop = 1'b1;
                    nxt    = rstack_reg[rtop_idx];
                end
            end
            default: st = ST_BADCMD;
        endcase
    end

    assign push_val = iter_req ? it_result : simple_val;
    assign dbase    = dcnt_reg - DCW'(pop_n);
    assign wa       = dbase[DAW-1:0];

    always_comb begin
        dcnt_next = dbase + DCW'(push_en);
        rcnt_next = rcnt_reg;
        if (rs_push) rcnt_next = rcnt_reg + RCW'(1);
        else if (rs_pop) rcnt_next = rm1;
    end

    smeu_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.it_start),
        .op      (it_op),
        .opa     (a),
        .opb     (b),
        .done    (it_done),
        .result  (it_result)
    );

    always_ff @(posedge aclk) begin
        if (cmd.latch) item_reg <= s_data;
    end

    // data stack: one write port, two registered read ports at the top
    always_ff @(posedge aclk) begin
        if (cmd.commit && push_en) dmem[wa] <= push_val;
        if (cmd.rd) begin
            rd_a_reg <= dmem[dm1[DAW-1:0]];
            rd_b_reg <= dmem[dm2[DAW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && rs_push) rstack_reg[rcnt_reg[RAW-1:0]] <= ia_p1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg    <= '0;
            rcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) regs_reg[i] <= 32'd0;
        end else begin
            if (cmd.commit) begin
                dcnt_reg    <= dcnt_next;
                rcnt_reg    <= rcnt_next;
                m_valid_reg <= 1'b1;
                if (reg_we) regs_reg[ridx] <= a;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_item_reg.status    <= st;
            m_item_reg.out_valid <= ovalid;
            m_item_reg.out_value <= ov;
            m_item_reg.next_addr <= nxt;
        end
    end

    assign stat.iter_req = iter_req;
    assign stat.it_done  = it_done;
    assign stat.out_free = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_data        = m_item_reg;

endmodule

>>> hdl/smeu_ctrl.sv
// Controller state machine sequencing accept, operand read, execute and iterate.
module smeu_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  smeu_pkg::dp_stat_t  stat,
    output smeu_pkg::ctrl_cmd_t cmd
);
    import smeu_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.rd     = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (stat.iter_req) begin
                    cmd.it_start = 1'b1;
                    state_next   = S_ITER;
                end else if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ITER: begin
                // hold until the unit is done and the result register is free
                if (stat.it_done && stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

>>> hdl/smeu_checker.sv
// Port-level checker for the stack machine execute unit, with its bind.
module smeu_props (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input smeu_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input smeu_pkg::out_item_t m_data
);
    import smeu_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat taken while one is in flight");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_out_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_valid |-> m_data.status == ST_OK)
        else $error("emitted value with an error status");

    a_out_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.out_valid |-> m_data.out_value == 32'sd0)
        else $error("out_value not zero without out_valid");

endmodule

bind stack_machine_execute_unit smeu_props u_smeu_props (.*);
